/* hdl/fpwb_pkg.sv */
// Shared types, constants and the blend function of the pixel write/blend block.
`default_nettype none
package fpwb_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int DIM_W          = 8;   // frame_width / frame_height registers
	localparam int CFG_IDX_W      = 1;
	localparam int X_W            = 7;
	localparam int Y_W            = 7;
	localparam int WORD_W         = 32;
	localparam int IDX_W          = 16;  // index < 255*255 for any frame size
	localparam int CNT_W          = 17;  // clear sweep counter, holds w*h itself
	localparam int CMDQ_DEPTH     = 4;
	localparam int RESQ_DEPTH     = 2;
	localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_BLEND = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} dims_t;

	typedef struct packed {
		op_t               op;
		logic              err;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] pixel;
		logic              status;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input int unsigned lim);
		logic [DIM_W-1:0] r;
		r = v;
		if (32'(v) > lim) begin
			r = DIM_W'(lim);
		end
		return r;
	endfunction

	function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		logic [15:0] sum;
		sum = ({8'd0, s} * {8'd0, a}) + ({8'd0, d} * {8'd0, 8'hFF - a});
		return sum[15:8];
	endfunction

	function automatic logic [WORD_W-1:0] blend_word(input logic [WORD_W-1:0] src,
			input logic [WORD_W-1:0] dst);
		logic [7:0] a;
		a = src[7:0];
		return {mix_chan(src[31:24], dst[31:24], a),
			mix_chan(src[23:16], dst[23:16], a),
			mix_chan(src[15:8], dst[15:8], a), 8'hFF};
	endfunction

endpackage
`default_nettype wire

/* hdl/fpwb_fifo.sv */
// Small synchronous word queue with flop storage.
`default_nettype none
module fpwb_fifo import fpwb_pkg::*; #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wdata,
	output logic                   full,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      rdata,
	output logic                   empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [PTR_W-1:0]  wp_q, rp_q;
	logic [PTR_W:0]    cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == (PTR_W+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rp_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= nxt(wp_q);
			if (do_pop) rp_q <= nxt(rp_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) store_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

/* hdl/fpwb_front.sv */
// Front end: frame size registers, range check and flipped pixel index.
`default_nettype none
module fpwb_front import fpwb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic [1:0]           cmd,
	input  wire logic [X_W-1:0]       x,
	input  wire logic [Y_W-1:0]       y,
	input  wire logic [WORD_W-1:0]    value,
	output dims_t                     dims,
	output item_t                     item
);
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w, h, row;
	logic [IDX_W-1:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w = clamp_dim(width_q, MAX_WIDTH);
	assign h = clamp_dim(height_q, MAX_HEIGHT);
	assign dims = '{w: w, h: h};

	// row counted top-down; only meaningful when in range
	assign row  = h - 8'd1 - {1'b0, y};
	assign prod = {8'd0, row} * {8'd0, w};

	always_comb begin
		item.op    = op_t'(cmd);
		item.err   = (op_t'(cmd) != OP_CLEAR) &&
			(({1'b0, x} >= w) || ({1'b0, y} >= h));
		item.idx   = prod + {9'd0, x};
		item.value = value;
	end

endmodule
`default_nettype wire

/* hdl/fpwb_back.sv */
// Back end: pixel memory, read-modify-write for blend, clear sweep, results.
`default_nettype none
module fpwb_back import fpwb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  dims_t      dims,
	input  item_t      cq_item,
	input  wire logic  cq_empty,
	output logic       cq_pop,
	output res_t       res,
	output logic       res_push,
	input  wire logic  res_full
);
	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CLEAR} state_t;

	logic [WORD_W-1:0] mem [Depth];
	state_t            state_q;
	op_t               op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] val_q, rd_q, fill_q;
	logic [CNT_W-1:0]  total_q, clr_pos_q;

	logic              mem_we, mem_re, take;
	logic [AddrW-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata, blended;

	assign take    = (state_q == ST_IDLE) && !cq_empty && !res_full;
	assign cq_pop  = take;
	assign blended = blend_word(val_q, rd_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = AddrW'(cq_item.idx);
		mem_wdata = cq_item.value;
		res_push  = 1'b0;
		res       = '{pixel: '0, status: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (cq_item.err) begin
						res_push   = 1'b1;
						res.status = 1'b1;
					end else begin
						case (cq_item.op)
							OP_WRITE: begin
								mem_we    = 1'b1;
								res_push  = 1'b1;
								res.pixel = cq_item.value;
							end
							OP_BLEND, OP_READ: mem_re = 1'b1;
							default: ;
						endcase
					end
				end
			end
			ST_READ: begin
				res_push  = 1'b1;
				mem_waddr = AddrW'(idx_q);
				mem_wdata = blended;
				if (op_q == OP_BLEND) begin
					mem_we    = 1'b1;
					res.pixel = blended;
				end else begin
					res.pixel = rd_q;
				end
			end
			ST_CLEAR: begin
				mem_waddr = AddrW'(clr_pos_q);
				mem_wdata = fill_q;
				if (clr_pos_q == total_q) res_push = 1'b1;
				else mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[AddrW'(cq_item.idx)];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= cq_item.op;
			idx_q   <= cq_item.idx;
			val_q   <= cq_item.value;
			fill_q  <= {4{cq_item.value[7:0]}};
			total_q <= CNT_W'({8'd0, dims.w} * {8'd0, dims.h});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			clr_pos_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					clr_pos_q <= '0;
					if (take && !cq_item.err) begin
						if (cq_item.op == OP_BLEND || cq_item.op == OP_READ)
							state_q <= ST_READ;
						else if (cq_item.op == OP_CLEAR)
							state_q <= ST_CLEAR;
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_CLEAR: begin
					if (clr_pos_q == total_q) begin
						state_q   <= ST_IDLE;
						clr_pos_q <= '0;
					end else begin
						clr_pos_q <= clr_pos_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result queue has room whenever a result is produced
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");

	a_clr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (clr_pos_q <= total_q))
		else $error("clear sweep ran past frame");

	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !cq_item.err && (cq_item.op == OP_BLEND || cq_item.op == OP_READ))
		|=> (state_q == ST_READ && res_push)) else $error("read/blend result missing");

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cq_pop) else $error("pop while busy");

endmodule
`default_nettype wire

/* hdl/framebuffer_pixel_write_blend_core.sv */
// Top level of the framebuffer pixel write/blend unit.
// Write/range error: result pushed as taken; read/blend: pixel registered, then
// result pushed, blend written back (single-port read then write-back); clear:
// one pixel written per cycle, then result pushed. Writes: one word per cycle
// while the result queue has room; read/blend/clear block the next command.
// Reset async active low: queues empty, frame 128x128; pixel memory not cleared.
`default_nettype none
module framebuffer_pixel_write_blend_core import fpwb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           cmd,
	input  wire logic [X_W-1:0]       x,
	input  wire logic [Y_W-1:0]       y,
	input  wire logic [WORD_W-1:0]    value,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [WORD_W-1:0]         pixel_out,
	output logic                      status
);
	dims_t dims;
	item_t f_item, cq_item;
	res_t  res_in, res_out;
	logic  cq_empty, cq_pop, res_push, res_full;

	fpwb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .x(x), .y(y), .value(value),
		.dims(dims), .item(f_item)
	);

	fpwb_fifo #(.DATA_W($bits(item_t)), .DEPTH(CMDQ_DEPTH)) u_cmdq (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(f_item), .full(full),
		.pop(cq_pop), .rdata(cq_item), .empty(cq_empty)
	);

	fpwb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .dims(dims),
		.cq_item(cq_item), .cq_empty(cq_empty), .cq_pop(cq_pop),
		.res(res_in), .res_push(res_push), .res_full(res_full)
	);

	fpwb_fifo #(.DATA_W($bits(res_t)), .DEPTH(RESQ_DEPTH)) u_resq (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .wdata(res_in), .full(res_full),
		.pop(pop), .rdata(res_out), .empty(empty)
	);

	assign pixel_out = res_out.pixel;
	assign status    = res_out.status;

endmodule
`default_nettype wire
